// ----- design/drt_pkg.sv -----
// ----------------------------------------------------------------------------
// drt_pkg
// shared constants, types and codes of the dedup row table
// ----------------------------------------------------------------------------
package drt_pkg;

   localparam int MAX_ROWS_DEF    = 64;
   localparam int MAX_COLUMNS_DEF = 8;
   localparam int MAX_RESULTS     = 64;
   localparam int CODE_W          = 32;
   localparam int NUM_FIELDS      = 8;

   typedef enum logic [1:0] {
      KIND_DEDUP  = 2'd0,
      KIND_DIRECT = 2'd1,
      KIND_READ   = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_TOO_LONG  = 3'd2,
      ST_FULL      = 3'd3,
      ST_READ      = 3'd4,
      ST_NO_ROW    = 3'd5,
      ST_QUERY     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WAIT,
      S_FLUSH,
      S_RESULT
   } state_type;

   // per-row compare results from the lanes toward the merge logic
   typedef struct packed {
      logic all_equal;
      logic mask_match;
   } lane_hit_type;

endpackage

// ----- design/drt_ram.sv -----
// ----------------------------------------------------------------------------
// drt_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module drt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/drt_lane.sv -----
// ----------------------------------------------------------------------------
// drt_lane
// one column lane: stores its column of every row and compares it with a key
// ----------------------------------------------------------------------------
module drt_lane #(
   parameter int MAX_ROWS = drt_pkg::MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(MAX_ROWS)-1:0] addr,
   input  logic [drt_pkg::CODE_W-1:0]  wr_data,
   input  logic [drt_pkg::CODE_W-1:0]  key,
   input  logic                        mask_bit,
   input  logic                        in_use,
   output logic [drt_pkg::CODE_W-1:0]  rd_data,
   output drt_pkg::lane_hit_type       hit
);

   drt_ram #(.WIDTH(drt_pkg::CODE_W), .DEPTH(MAX_ROWS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   always_comb begin
      hit.all_equal  = (rd_data == key);
      hit.mask_match = !mask_bit || (in_use && (rd_data == key));
   end

endmodule

// ----- design/dedup_row_table_with_column_match_unit.sv -----
// ----------------------------------------------------------------------------
// dedup_row_table_with_column_match_unit
// row table with direct and duplicate-searching insert, row read and masked query
// ----------------------------------------------------------------------------
//  channel  | ports               | direction | moves
//  request  | req_valid/req_ready | in        | one operation transaction
//  response | rsp_valid/rsp_ready | out       | result transactions, last marks end
//  csr      | csr_we/csr_wdata    | in        | columns_in_use write
//
//  a reject is valid right after the accepting edge; a direct insert passes
//  through the result state and a read through the wait and result states; a
//  dedup insert or query scans the stored rows one a cycle through the column
//  lane rams while no stalled response holds the scan, and its final response
//  follows the scan (earlier on a duplicate), plus any response stall; the
//  next request is taken at the edge that takes the last response.
//  reset clears rows_held, columns_in_use and control; ram contents stay
//  undefined and are only used below rows_held.
//  a stalled response holds the scan in place; one transaction at a time.
// ----------------------------------------------------------------------------
module dedup_row_table_with_column_match_unit #(
   parameter int MAX_ROWS    = drt_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLUMNS = drt_pkg::MAX_COLUMNS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_row_length,
   input  logic [31:0] req_column_0,
   input  logic [31:0] req_column_1,
   input  logic [31:0] req_column_2,
   input  logic [31:0] req_column_3,
   input  logic [31:0] req_column_4,
   input  logic [31:0] req_column_5,
   input  logic [31:0] req_column_6,
   input  logic [31:0] req_column_7,
   input  logic [7:0]  req_match_mask,
   input  logic [5:0]  req_row_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_found,
   output logic [5:0]  rsp_result_row,
   output logic [31:0] rsp_out_0,
   output logic [31:0] rsp_out_1,
   output logic [31:0] rsp_out_2,
   output logic [31:0] rsp_out_3,
   output logic [31:0] rsp_out_4,
   output logic [31:0] rsp_out_5,
   output logic [31:0] rsp_out_6,
   output logic [31:0] rsp_out_7,
   output logic        rsp_last
);

   localparam int AW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS + 1);
   localparam int NF = drt_pkg::NUM_FIELDS;
   localparam int W  = drt_pkg::CODE_W;

   drt_pkg::state_type state_ff, state_in;

   logic [3:0]    cols_ff, cols_in;
   logic [CW-1:0] rows_ff, rows_in;

   // captured transaction
   drt_pkg::kind_type kind_ff, kind_in;
   logic [W-1:0]  key_ff [NF];
   logic [W-1:0]  key_in [NF];
   logic [NF-1:0] mask_ff, mask_in;
   logic [CW-1:0] idx_ff, idx_in;        // scan address / read address
   logic          inflight_ff, inflight_in; // a ram read of idx-1 arrives
   logic [6:0]    nres_ff, nres_in;

   // response register
   logic          rv_ff, rv_in;
   logic [2:0]    rs_ff, rs_in;
   logic          rf_ff, rf_in;
   logic [5:0]    rr_ff, rr_in;
   logic [W-1:0]  ro_ff [NF];
   logic [W-1:0]  ro_in [NF];
   logic          rl_ff, rl_in;
   // one pending match held back to learn whether it is the last
   logic          pv_ff, pv_in;
   logic [5:0]    prow_ff, prow_in;

   logic [W-1:0] req_col [NF];
   assign req_col[0] = req_column_0;
   assign req_col[1] = req_column_1;
   assign req_col[2] = req_column_2;
   assign req_col[3] = req_column_3;
   assign req_col[4] = req_column_4;
   assign req_col[5] = req_column_5;
   assign req_col[6] = req_column_6;
   assign req_col[7] = req_column_7;

   // lane interface
   logic                  ram_we;
   logic [AW-1:0]         ram_addr;
   logic [W-1:0]          rd  [NF];
   drt_pkg::lane_hit_type hit [NF];

   genvar g;
   generate
      for (g = 0; g < NF; g++) begin : g_lane
         if (g < MAX_COLUMNS) begin : g_on
            drt_lane #(.MAX_ROWS(MAX_ROWS)) u_lane (
               .clock   (clock),
               .wr_en   (ram_we),
               .addr    (ram_addr),
               .wr_data (key_ff[g]),
               .key     (key_ff[g]),
               .mask_bit(mask_ff[g]),
               .in_use  (cols_ff > 4'(g)),
               .rd_data (rd[g]),
               .hit     (hit[g])
            );
         end else begin : g_off
            // missing column: stored zero, masked compare never matches
            assign rd[g]            = '0;
            assign hit[g].all_equal  = (key_ff[g] == '0);
            assign hit[g].mask_match = !mask_ff[g];
         end
      end
   endgenerate

   // merge stage across lanes
   logic row_equal, row_match;
   always_comb begin
      row_equal = 1'b1;
      row_match = 1'b1;
      for (int c = 0; c < NF; c++) begin
         row_equal = row_equal & hit[c].all_equal;
         row_match = row_match & hit[c].mask_match;
      end
   end

   logic out_free;
   assign out_free  = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == drt_pkg::S_IDLE) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= drt_pkg::S_IDLE;
         cols_ff     <= '0;
         rows_ff     <= '0;
         rv_ff       <= 1'b0;
         pv_ff       <= 1'b0;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cols_ff     <= cols_in;
         rows_ff     <= rows_in;
         rv_ff       <= rv_in;
         pv_ff       <= pv_in;
         inflight_ff <= inflight_in;
      end
      kind_ff <= kind_in;
      key_ff  <= key_in;
      mask_ff <= mask_in;
      idx_ff  <= idx_in;
      nres_ff <= nres_in;
      rs_ff   <= rs_in;
      rf_ff   <= rf_in;
      rr_ff   <= rr_in;
      ro_ff   <= ro_in;
      rl_ff   <= rl_in;
      prow_ff <= prow_in;
   end

   // register write: saturate, never shrink
   logic [3:0] csr_sat;
   always_comb begin
      csr_sat = (csr_wdata > 4'(MAX_COLUMNS)) ? 4'(MAX_COLUMNS) : csr_wdata;
      cols_in = (csr_we && csr_sat > cols_ff) ? csr_sat : cols_ff;
   end

   logic [CW-1:0] prev_idx;
   logic [5:0]    prev_row;
   assign prev_idx = idx_ff - CW'(1);
   assign prev_row = 6'(prev_idx);

   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      mask_in     = mask_ff;
      idx_in      = idx_ff;
      inflight_in = 1'b0;
      nres_in     = nres_ff;
      rv_in       = rv_ff && !rsp_ready;
      rs_in       = rs_ff;
      rf_in       = rf_ff;
      rr_in       = rr_ff;
      ro_in       = ro_ff;
      rl_in       = rl_ff;
      pv_in       = pv_ff;
      prow_in     = prow_ff;
      ram_we      = 1'b0;
      ram_addr    = AW'(idx_ff);

      unique case (state_ff)
         drt_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               kind_in = drt_pkg::kind_type'(req_kind);
               mask_in = req_match_mask;
               nres_in = '0;
               idx_in  = '0;
               for (int c = 0; c < NF; c++) begin
                  key_in[c] = req_col[c];
                  if ((req_kind == drt_pkg::KIND_DEDUP || req_kind == drt_pkg::KIND_DIRECT) &&
                      4'(c) >= req_row_length) begin
                     key_in[c] = '0;
                  end
               end
               for (int c = 0; c < NF; c++) begin
                  ro_in[c] = '0;
               end
               rf_in = 1'b0;
               rr_in = '0;
               rl_in = 1'b1;
               unique case (drt_pkg::kind_type'(req_kind)) inside
                  drt_pkg::KIND_DEDUP, drt_pkg::KIND_DIRECT: begin
                     if (req_row_length > cols_ff) begin
                        rs_in = drt_pkg::ST_TOO_LONG;
                        rv_in = 1'b1;
                     end else if (req_kind == drt_pkg::KIND_DEDUP) begin
                        state_in = drt_pkg::S_SCAN;
                     end else begin
                        state_in = drt_pkg::S_RESULT;
                     end
                  end
                  drt_pkg::KIND_READ: begin
                     if (CW'(req_row_index) >= rows_ff ||
                         32'(req_row_index) >= MAX_ROWS) begin
                        rs_in = drt_pkg::ST_NO_ROW;
                        rv_in = 1'b1;
                     end else begin
                        idx_in   = CW'(req_row_index);
                        state_in = drt_pkg::S_WAIT;
                     end
                  end
                  default: begin
                     state_in = drt_pkg::S_SCAN;
                  end
               endcase
            end
         end

         // one row per cycle unless stalled; the compare uses the read of the row before
         drt_pkg::S_SCAN: begin
            if (out_free || !inflight_ff) begin
               if (inflight_ff && kind_ff == drt_pkg::KIND_DEDUP && row_equal) begin
                  rs_in    = drt_pkg::ST_DUPLICATE;
                  rr_in    = prev_row;
                  rv_in    = 1'b1;
                  state_in = drt_pkg::S_IDLE;
               end else begin
                  if (inflight_ff && kind_ff == drt_pkg::KIND_QUERY && row_match &&
                      nres_ff < 7'(drt_pkg::MAX_RESULTS)) begin
                     nres_in = nres_ff + 7'd1;
                     if (pv_ff) begin
                        rs_in = drt_pkg::ST_QUERY;
                        rf_in = 1'b1;
                        rr_in = prow_ff;
                        rl_in = 1'b0;
                        rv_in = 1'b1;
                     end
                     pv_in   = 1'b1;
                     prow_in = prev_row;
                  end
                  if (idx_ff < rows_ff) begin
                     inflight_in = 1'b1;
                     idx_in      = idx_ff + CW'(1);
                  end else begin
                     state_in = (kind_ff == drt_pkg::KIND_QUERY) ?
                                drt_pkg::S_FLUSH : drt_pkg::S_RESULT;
                  end
               end
            end else begin
               // response stalled: reissue the same read
               inflight_in = 1'b1;
               ram_addr    = AW'(prev_idx);
            end
         end

         drt_pkg::S_FLUSH: begin
            if (out_free) begin
               rs_in    = drt_pkg::ST_QUERY;
               rf_in    = pv_ff;
               rr_in    = pv_ff ? prow_ff : 6'd0;
               rl_in    = 1'b1;
               rv_in    = 1'b1;
               pv_in    = 1'b0;
               state_in = drt_pkg::S_IDLE;
            end
         end

         drt_pkg::S_WAIT: begin
            state_in = drt_pkg::S_RESULT;
         end

         drt_pkg::S_RESULT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               rl_in    = 1'b1;
               state_in = drt_pkg::S_IDLE;
               if (kind_ff == drt_pkg::KIND_READ) begin
                  rs_in = drt_pkg::ST_READ;
                  rr_in = 6'(idx_ff);
                  for (int c = 0; c < NF; c++) begin
                     ro_in[c] = rd[c];
                  end
               end else if (rows_ff >= CW'(MAX_ROWS)) begin
                  rs_in = drt_pkg::ST_FULL;
               end else begin
                  // append, zeroing columns beyond the row length
                  ram_we   = 1'b1;
                  ram_addr = AW'(rows_ff);
                  rs_in    = drt_pkg::ST_INSERTED;
                  rr_in    = 6'(rows_ff);
                  rows_in  = rows_ff + CW'(1);
               end
            end
         end

         default: begin
            state_in = drt_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rs_ff;
   assign rsp_found      = rf_ff;
   assign rsp_result_row = rr_ff;
   assign rsp_out_0      = ro_ff[0];
   assign rsp_out_1      = ro_ff[1];
   assign rsp_out_2      = ro_ff[2];
   assign rsp_out_3      = ro_ff[3];
   assign rsp_out_4      = ro_ff[4];
   assign rsp_out_5      = ro_ff[5];
   assign rsp_out_6      = ro_ff[6];
   assign rsp_out_7      = ro_ff[7];
   assign rsp_last       = rl_ff;

endmodule

// ----- sim/dedup_row_table_with_column_match_unit_tb.sv -----
// ----------------------------------------------------------------------------
// dedup_row_table_with_column_match_unit_tb
// self-checking bench: directed and random operations against a predictor
// ----------------------------------------------------------------------------
// every request transaction is predicted on acceptance by a model of the row
// table kept inside this bench; a monitor compares each response transaction
// field by field with the oldest expected one. the column count only grows,
// so the run walks it upward through several settings while the table fills
// ----------------------------------------------------------------------------
module dedup_row_table_with_column_match_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS       = drt_pkg::MAX_ROWS_DEF;
   localparam int COLS       = drt_pkg::MAX_COLUMNS_DEF;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      drt_pkg::status_type status;
      logic                found;
      logic [5:0]          row;
      logic [7:0][31:0]    data;
      logic                last;
   } rsp_type;

   typedef struct {
      drt_pkg::kind_type kind;
      logic [3:0]        len;
      logic [31:0]       col [COLS];
      logic [7:0]        mask;
      logic [5:0]        idx;
   } req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [3:0]  csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [3:0]  req_row_length = '0;
   logic [31:0] req_column [COLS];
   logic [7:0]  req_match_mask = '0;
   logic [5:0]  req_row_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_found;
   logic [5:0]  rsp_result_row;
   logic [31:0] rsp_out [COLS];
   logic        rsp_last;

   // predictor state
   logic [31:0] table_rows [ROWS][COLS];
   int          row_count;
   int          col_count;
   rsp_type     expected_rsp [$];

   int  errors;
   int  sent_items;
   int  got_rsps;
   int  idle_cycles;
   int  kind_seen [4];
   bit  done;

   initial begin
      for (int c = 0; c < COLS; c++) req_column[c] = '0;
   end

   dedup_row_table_with_column_match_unit u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_row_length(req_row_length),
      .req_column_0(req_column[0]), .req_column_1(req_column[1]),
      .req_column_2(req_column[2]), .req_column_3(req_column[3]),
      .req_column_4(req_column[4]), .req_column_5(req_column[5]),
      .req_column_6(req_column[6]), .req_column_7(req_column[7]),
      .req_match_mask(req_match_mask), .req_row_index(req_row_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_found(rsp_found), .rsp_result_row(rsp_result_row),
      .rsp_out_0(rsp_out[0]), .rsp_out_1(rsp_out[1]), .rsp_out_2(rsp_out[2]),
      .rsp_out_3(rsp_out[3]), .rsp_out_4(rsp_out[4]), .rsp_out_5(rsp_out[5]),
      .rsp_out_6(rsp_out[6]), .rsp_out_7(rsp_out[7]), .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // build one response record
   function automatic rsp_type make_rsp(drt_pkg::status_type st, logic fnd, int row, bit lst);
      rsp_type r;
      r.status = st;
      r.found  = fnd;
      r.row    = row[5:0];
      r.data   = '0;
      r.last   = lst;
      return r;
   endfunction

   // append one expected response transaction
   function automatic void queue_rsp(rsp_type r);
      expected_rsp.insert(expected_rsp.size(), r);
   endfunction

   // predict the response transactions of one accepted request
   task automatic predict_table_op(req_type q);
      logic [31:0] padded [COLS];
      rsp_type     r;
      rsp_type     held;
      bit          have_held;
      int          hits;
      bit          ok;
      kind_seen[q.kind]++;
      have_held = 1'b0;
      held      = '0;
      if (q.kind == drt_pkg::KIND_DEDUP || q.kind == drt_pkg::KIND_DIRECT) begin
         if (q.len > col_count) begin
            queue_rsp(make_rsp(drt_pkg::ST_TOO_LONG, 1'b0, 0, 1'b1));
            return;
         end
         for (int c = 0; c < COLS; c++) padded[c] = (c < q.len) ? q.col[c] : '0;
         if (q.kind == drt_pkg::KIND_DEDUP) begin
            for (int i = 0; i < row_count; i++) begin
               ok = 1'b1;
               for (int c = 0; c < COLS; c++)
                  if (table_rows[i][c] != padded[c]) ok = 1'b0;
               if (ok) begin
                  queue_rsp(make_rsp(drt_pkg::ST_DUPLICATE, 1'b0, i, 1'b1));
                  return;
               end
            end
         end
         if (row_count >= ROWS) begin
            queue_rsp(make_rsp(drt_pkg::ST_FULL, 1'b0, 0, 1'b1));
            return;
         end
         table_rows[row_count] = padded;
         queue_rsp(make_rsp(drt_pkg::ST_INSERTED, 1'b0, row_count, 1'b1));
         row_count++;
      end else if (q.kind == drt_pkg::KIND_READ) begin
         if (q.idx >= row_count) begin
            queue_rsp(make_rsp(drt_pkg::ST_NO_ROW, 1'b0, 0, 1'b1));
            return;
         end
         r = make_rsp(drt_pkg::ST_READ, 1'b0, int'(q.idx), 1'b1);
         for (int c = 0; c < COLS; c++) r.data[c] = table_rows[q.idx][c];
         queue_rsp(r);
      end else begin
         hits = 0;
         for (int i = 0; i < row_count && hits < drt_pkg::MAX_RESULTS; i++) begin
            ok = 1'b1;
            for (int c = 0; c < COLS; c++)
               if (q.mask[c] && (c >= col_count || table_rows[i][c] != q.col[c]))
                  ok = 1'b0;
            if (ok) begin
               // hold each match back until the next one shows it is not last
               if (have_held) queue_rsp(held);
               held      = make_rsp(drt_pkg::ST_QUERY, 1'b1, i, 1'b0);
               have_held = 1'b1;
               hits++;
            end
         end
         if (!have_held) begin
            queue_rsp(make_rsp(drt_pkg::ST_QUERY, 1'b0, 0, 1'b1));
         end else begin
            held.last = 1'b1;
            queue_rsp(held);
         end
      end
   endtask

   // send one request transaction; burst/gap shaping on the sender side
   int burst_left;
   task automatic send_item(req_type q);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_kind       <= q.kind;
      req_row_length <= q.len;
      for (int c = 0; c < COLS; c++) req_column[c] <= q.col[c];
      req_match_mask <= q.mask;
      req_row_index  <= q.idx;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_table_op(q);
      sent_items++;
   endtask

   // wait until every expected response has arrived, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_columns(logic [3:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      // shrinks are ignored, large values saturate
      if (value > 4'(COLS)) value = 4'(COLS);
      if (int'(value) > col_count) col_count = int'(value);
   endtask

   function automatic req_type rand_item(drt_pkg::kind_type k);
      req_type q;
      q.kind = k;
      q.len  = 4'($urandom_range(0, col_count));
      for (int c = 0; c < COLS; c++) q.col[c] = $urandom;
      q.mask = 8'($urandom);
      q.idx  = 6'($urandom_range(0, 63));
      return q;
   endfunction

   // small code alphabet so duplicates and query hits are common
   function automatic req_type narrow_item(drt_pkg::kind_type k);
      req_type q;
      q = rand_item(k);
      for (int c = 0; c < COLS; c++) q.col[c] = $urandom_range(0, 2);
      return q;
   endfunction

   // directed: extremes, every kind and each corner
   task automatic test_directed();
      req_type q;
      // with zero columns only empty rows fit
      q = rand_item(drt_pkg::KIND_DEDUP); q.len = 4'd1; send_item(q);    // too long
      q = rand_item(drt_pkg::KIND_READ); q.idx = 6'd0; send_item(q);     // no row yet
      q = rand_item(drt_pkg::KIND_QUERY); q.mask = 8'h00; send_item(q); // empty table
      q = rand_item(drt_pkg::KIND_DEDUP); q.len = 4'd0; send_item(q);
      q = rand_item(drt_pkg::KIND_DEDUP); q.len = 4'd0; send_item(q);    // duplicate
      drain();
      write_columns(4'd3);
      write_columns(4'd1);                                    // shrink ignored
      q = rand_item(drt_pkg::KIND_DIRECT); q.len = 4'd3;
      for (int c = 0; c < COLS; c++) q.col[c] = 32'hFFFF_FFFF;
      send_item(q);
      q.kind = drt_pkg::KIND_DEDUP; send_item(q);             // duplicate of row 1
      q.len = 4'd4; send_item(q);                             // too long
      q = rand_item(drt_pkg::KIND_DIRECT); q.len = 4'd3;
      for (int c = 0; c < COLS; c++) q.col[c] = '0;
      send_item(q);
      q = rand_item(drt_pkg::KIND_READ); q.idx = 6'd1; send_item(q);
      q.idx = 6'd63; send_item(q);
      q = rand_item(drt_pkg::KIND_QUERY);
      for (int c = 0; c < COLS; c++) q.col[c] = 32'hFFFF_FFFF;
      q.mask = 8'h07; send_item(q);
      q.mask = 8'h08; send_item(q);                           // beyond schema
      q.mask = 8'hFF; send_item(q);
      q.mask = 8'h00; send_item(q);                           // every row
      drain();
      write_columns(4'd15);                                   // saturates
      q = rand_item(drt_pkg::KIND_READ); q.idx = 6'd1; send_item(q); // new columns zero
      q = rand_item(drt_pkg::KIND_DEDUP); q.len = 4'd8;
      for (int c = 0; c < COLS; c++) q.col[c] = 32'h8000_0000 >> c;
      send_item(q);
      q.kind = drt_pkg::KIND_READ; q.idx = 6'd4; send_item(q);
      q = rand_item(drt_pkg::KIND_QUERY); q.col[7] = 32'h0100_0000; q.mask = 8'h80;
      send_item(q);
      drain();
   endtask

   // random: mostly narrow codes; fill the table to exercise full
   task automatic test_random();
      req_type           q;
      drt_pkg::kind_type k;
      for (int i = 0; i < 190; i++) begin
         k = drt_pkg::kind_type'($urandom_range(0, 3));
         if ($urandom_range(0, 3) == 0) q = rand_item(k);
         else q = narrow_item(k);
         if (k == drt_pkg::KIND_READ && $urandom_range(0, 1)) q.idx = 6'($urandom_range(0, 2));
         send_item(q);
      end
      drain();
   endtask

   // receiver stall pattern: periodic runs plus random stalls, with clean spans
   int stall_phase;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[7:6] == 2'b00) rsp_ready <= 1'b1;
      else if (stall_phase[3:2] == 2'b11) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // response checker
   always @(posedge clock) begin
      rsp_type got, exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = drt_pkg::status_type'(rsp_status);
         got.found  = rsp_found;
         got.row    = rsp_result_row;
         for (int c = 0; c < COLS; c++) got.data[c] = rsp_out[c];
         got.last   = rsp_last;
         got_rsps++;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response transaction %p", got);
         end else begin
            exp_r = expected_rsp.pop_front();
            if (got !== exp_r) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %p actual %p", exp_r, got);
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!done && idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      errors = 0; sent_items = 0; got_rsps = 0; idle_cycles = 0;
      burst_left = 0; stall_phase = 0; row_count = 0; col_count = 0; done = 0;
      for (int k = 0; k < 4; k++) kind_seen[k] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      done = 1;
      $display("covered %0d requests (dedup %0d direct %0d read %0d query %0d), %0d responses",
               sent_items, kind_seen[drt_pkg::KIND_DEDUP], kind_seen[drt_pkg::KIND_DIRECT],
               kind_seen[drt_pkg::KIND_READ], kind_seen[drt_pkg::KIND_QUERY], got_rsps);
      $display("table ended with %0d rows at %0d columns", row_count, col_count);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
